[src/uart_register_file_defines.svh]
// assertion helpers shared by the register file
`ifndef UART_REGISTER_FILE_DEFINES_SVH
`define UART_REGISTER_FILE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define URF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define URF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/urf_pkg.sv]
`default_nettype none

package urf_pkg;

  localparam int unsigned DEFAULT_FIFO_DEPTH = 16;

  typedef enum logic [1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RECEIVE = 2'd2,
    CMD_TICK    = 2'd3
  } command_t;

  // register offsets
  localparam logic [2:0] REG_DATA = 3'd0;
  localparam logic [2:0] REG_IER  = 3'd1;
  localparam logic [2:0] REG_IIR  = 3'd2;
  localparam logic [2:0] REG_LCR  = 3'd3;
  localparam logic [2:0] REG_LSR  = 3'd5;

  localparam int unsigned DLAB_POS = 7;

  localparam logic [7:0] LSR_DR    = 8'h01;
  localparam logic [7:0] LSR_OE    = 8'h02;
  localparam logic [7:0] LSR_THRE  = 8'h20;
  localparam logic [7:0] LSR_TEMT  = 8'h40;

  localparam logic [7:0] IIR_NONE  = 8'h01;
  localparam logic [7:0] IIR_THRE  = 8'h02;
  localparam logic [7:0] IIR_RDA   = 8'h04;
  localparam logic [7:0] IIR_FIFOS = 8'hC0;

  typedef struct packed {
    command_t   command;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] line_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;
  } rsp_t;

  // one operation per word at most
  typedef struct packed {
    logic push;
    logic overwrite;
    logic pop;
    logic clear;
  } fifo_ctrl_t;

endpackage

`default_nettype wire

[src/urf_fifo.sv]
`default_nettype none

module urf_fifo #(
  parameter int unsigned DEPTH = urf_pkg::DEFAULT_FIFO_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire urf_pkg::fifo_ctrl_t        ctrl,
  input  wire logic [7:0]                 push_data,
  output logic [$clog2(DEPTH+1)-1:0]      count,
  output logic [7:0]                      head_data
);
  import urf_pkg::*;

  localparam int unsigned HW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [7:0]    mem [DEPTH];
  logic [HW-1:0] head;
  logic [HW-1:0] head_next;
  logic [CW-1:0] count_next;
  logic [SW-1:0] tail_sum;
  logic [HW-1:0] tail;
  logic [HW-1:0] head_inc;
  logic          wr_en;
  logic [HW-1:0] wr_addr;

  assign tail_sum = SW'(head) + SW'(count);
  assign tail     = (tail_sum >= SW'(DEPTH)) ? HW'(tail_sum - SW'(DEPTH)) : HW'(tail_sum);
  assign head_inc = (head == HW'(DEPTH - 1)) ? '0 : head + HW'(1);

  always_comb begin
    head_next  = head;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = tail;
    if (ctrl.clear) begin
      head_next  = '0;
      count_next = '0;
    end else if (ctrl.push) begin
      wr_en      = 1'b1;
      count_next = count + CW'(1);
    end else if (ctrl.overwrite) begin
      wr_en   = 1'b1;
      wr_addr = head;
    end else if (ctrl.pop) begin
      head_next  = head_inc;
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // head byte is kept registered; a write landing on the new head goes straight through
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= push_data;
    end
    if (wr_en && (wr_addr == head_next)) begin
      head_data <= push_data;
    end else begin
      head_data <= mem[head_next];
    end
  end

endmodule

`default_nettype wire

[src/uart_register_file.sv]
// channel | direction | handshake            | word
// req     | in        | req_valid/req_ready  | command, offset, write byte, line byte
// rsp     | out       | rsp_valid/rsp_ready  | read byte, tx strobe and byte, irq
//
// one word a cycle while rsp is not stalled: a request is registered, decoded against
// the register and fifo state, and its response registered.
// the fifo head bytes are held in registers fed from each fifo memory read port.
// rst clears all control, fifo pointers and registers; fifo contents are not cleared.
// a stalled rsp holds the request register, and req_ready drops until it drains.
`default_nettype none

`include "uart_register_file_defines.svh"

module uart_register_file #(
  parameter int unsigned FIFO_DEPTH = urf_pkg::DEFAULT_FIFO_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire urf_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output urf_pkg::rsp_t      rsp
);
  import urf_pkg::*;

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  req_t          inq;
  logic          inq_valid;
  logic          advance;

  logic [3:0]    int_enable, int_enable_next;
  logic [7:0]    line_control, line_control_next;
  logic [7:0]    divisor_low, divisor_low_next;
  logic [7:0]    divisor_high, divisor_high_next;
  logic          fifo_on, fifo_on_next;
  logic          overrun_flag, overrun_flag_next;

  fifo_ctrl_t    rx_op, tx_op, rx_ctrl, tx_ctrl;
  logic [CW-1:0] rx_count, tx_count;
  logic [7:0]    rx_head_data, tx_head_data;

  logic          dlab, rx_ready_data, tx_empty, rx_full, tx_full;
  logic          rx_has_after, tx_empty_after;
  logic [7:0]    iir;
  rsp_t          rsp_next;

  assign advance   = inq_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !inq_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (req_ready) begin
      inq_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      inq <= req;
    end
  end

  urf_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (rx_ctrl),
    .push_data (inq.line_byte),
    .count     (rx_count),
    .head_data (rx_head_data)
  );

  urf_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (tx_ctrl),
    .push_data (inq.write_data),
    .count     (tx_count),
    .head_data (tx_head_data)
  );

  assign rx_ctrl = advance ? rx_op : '0;
  assign tx_ctrl = advance ? tx_op : '0;

  assign dlab          = line_control[DLAB_POS];
  assign rx_ready_data = (rx_count != '0);
  assign tx_empty      = (tx_count == '0);
  assign rx_full       = fifo_on ? (rx_count == CW'(FIFO_DEPTH)) : rx_ready_data;
  assign tx_full       = fifo_on ? (tx_count == CW'(FIFO_DEPTH)) : !tx_empty;

  always_comb begin
    if (int_enable[0] && rx_ready_data) begin
      iir = IIR_RDA;
    end else if (int_enable[1] && tx_empty) begin
      iir = IIR_THRE;
    end else begin
      iir = IIR_NONE;
    end
    if (fifo_on) begin
      iir = iir | IIR_FIFOS;
    end
  end

  always_comb begin
    int_enable_next   = int_enable;
    line_control_next = line_control;
    divisor_low_next  = divisor_low;
    divisor_high_next = divisor_high;
    fifo_on_next      = fifo_on;
    overrun_flag_next = overrun_flag;
    rx_op             = '0;
    tx_op             = '0;
    rsp_next          = '0;
    case (inq.command)
      CMD_READ: begin
        case (inq.reg_offset)
          REG_DATA: begin
            if (dlab) begin
              rsp_next.read_data = divisor_low;
            end else if (rx_ready_data) begin
              rsp_next.read_data = rx_head_data;
              rx_op.pop          = 1'b1;
            end
          end
          REG_IER: begin
            rsp_next.read_data = dlab ? divisor_high : {4'b0, int_enable};
          end
          REG_IIR: begin
            rsp_next.read_data = iir;
          end
          REG_LCR: begin
            rsp_next.read_data = line_control;
          end
          REG_LSR: begin
            rsp_next.read_data = (rx_ready_data ? LSR_DR : 8'h00)
                               | (overrun_flag ? LSR_OE : 8'h00)
                               | (tx_empty ? (LSR_THRE | LSR_TEMT) : 8'h00);
            overrun_flag_next  = 1'b0;
          end
          default: begin
          end
        endcase
      end
      CMD_WRITE: begin
        case (inq.reg_offset)
          REG_DATA: begin
            if (dlab) begin
              divisor_low_next = inq.write_data;
            end else if (!tx_full) begin
              tx_op.push = 1'b1;
            end
          end
          REG_IER: begin
            if (dlab) begin
              divisor_high_next = inq.write_data;
            end else begin
              int_enable_next = inq.write_data[3:0];
            end
          end
          REG_IIR: begin
            // fcr: toggling the enable flushes both fifos
            if (inq.write_data[0] != fifo_on) begin
              fifo_on_next = inq.write_data[0];
              rx_op.clear  = 1'b1;
              tx_op.clear  = 1'b1;
            end else if (inq.write_data[0]) begin
              rx_op.clear = inq.write_data[1];
              tx_op.clear = inq.write_data[2];
            end
          end
          REG_LCR: begin
            line_control_next = inq.write_data;
          end
          default: begin
          end
        endcase
      end
      CMD_RECEIVE: begin
        if (!rx_full) begin
          rx_op.push = 1'b1;
        end else begin
          overrun_flag_next = 1'b1;
          rx_op.overwrite   = !fifo_on;
        end
      end
      CMD_TICK: begin
        if (!tx_empty) begin
          rsp_next.tx_valid = 1'b1;
          rsp_next.tx_byte  = tx_head_data;
          tx_op.pop         = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // interrupt level as it stands once this word has taken effect
    if (rx_op.clear) begin
      rx_has_after = 1'b0;
    end else if (rx_op.push) begin
      rx_has_after = 1'b1;
    end else if (rx_op.pop) begin
      rx_has_after = (rx_count != CW'(1));
    end else begin
      rx_has_after = rx_ready_data;
    end
    if (tx_op.clear) begin
      tx_empty_after = 1'b1;
    end else if (tx_op.push) begin
      tx_empty_after = 1'b0;
    end else if (tx_op.pop) begin
      tx_empty_after = (tx_count == CW'(1));
    end else begin
      tx_empty_after = tx_empty;
    end
    rsp_next.irq = (int_enable_next[0] && rx_has_after)
                 || (int_enable_next[1] && tx_empty_after);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      int_enable   <= '0;
      line_control <= '0;
      divisor_low  <= '0;
      divisor_high <= '0;
      fifo_on      <= 1'b0;
      overrun_flag <= 1'b0;
    end else if (advance) begin
      int_enable   <= int_enable_next;
      line_control <= line_control_next;
      divisor_low  <= divisor_low_next;
      divisor_high <= divisor_high_next;
      fifo_on      <= fifo_on_next;
      overrun_flag <= overrun_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  `URF_ASSERT_NOW(a_rx_within_capacity, 1'b1, (rx_count <= (fifo_on ? CW'(FIFO_DEPTH) : CW'(1))), "rx fifo count beyond capacity")
  `URF_ASSERT_NOW(a_tx_within_capacity, 1'b1, (tx_count <= (fifo_on ? CW'(FIFO_DEPTH) : CW'(1))), "tx fifo count beyond capacity")
  `URF_ASSERT_NEXT(a_lsr_read_clears_oe, advance && (inq.command == CMD_READ) && (inq.reg_offset == REG_LSR), !overrun_flag, "overrun flag survived lsr read")
  `URF_ASSERT_NEXT(a_tick_sends_byte, advance && (inq.command == CMD_TICK) && (tx_count != '0), rsp_valid && rsp.tx_valid, "tick with queued byte sent nothing")

endmodule

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
  import urf_pkg::*;

  localparam int unsigned FIFO_DEPTH     = DEFAULT_FIFO_DEPTH;
  localparam int unsigned RANDOM_WORDS   = 1370;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  // write side of offset 2, and the offsets this block leaves unused
  localparam logic [2:0] REG_FCR = REG_IIR;
  localparam logic [2:0] REG_MCR = 3'd4;
  localparam logic [2:0] REG_MSR = 3'd6;
  localparam logic [2:0] REG_SCR = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  always #1 clk = ~clk;

  uart_register_file #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  // shadow of the register file
  logic [7:0]  rx_fifo [FIFO_DEPTH];
  logic [7:0]  tx_fifo [FIFO_DEPTH];
  int unsigned rx_fill = 0;
  int unsigned rx_rd = 0;
  int unsigned tx_fill = 0;
  int unsigned tx_rd = 0;
  logic [3:0]  ier_q = '0;
  logic [7:0]  lcr_q = '0;
  logic [7:0]  dll_q = '0;
  logic [7:0]  dlm_q = '0;
  logic        fifo_en = 1'b0;
  logic        overrun = 1'b0;

  rsp_t expected_rsp [$];
  rsp_t oldest;

  int unsigned words_sent = 0;
  int unsigned rsp_seen = 0;
  int unsigned error_count = 0;
  int unsigned overrun_count = 0;
  int unsigned line_bytes = 0;
  int unsigned idle_cycles = 0;

  bit req_gaps_on = 1'b1;
  bit rsp_gaps_on = 1'b1;
  bit hold_request = 1'b0;

  function automatic logic rx_cause();
    return ier_q[0] && rx_fill != 0;
  endfunction

  function automatic logic tx_cause();
    return ier_q[1] && tx_fill == 0;
  endfunction

  function automatic rsp_t predict_response(input req_t w);
    rsp_t        r;
    logic        dlab;
    int unsigned room;
    r = '0;
    dlab = lcr_q[DLAB_POS];
    room = fifo_en ? FIFO_DEPTH : 1;
    case (w.command)
      CMD_READ: begin
        case (w.reg_offset)
          REG_DATA: begin
            if (dlab) begin
              r.read_data = dll_q;
            end else if (rx_fill != 0) begin
              r.read_data = rx_fifo[rx_rd];
              rx_rd = (rx_rd + 1) % FIFO_DEPTH;
              rx_fill--;
            end
          end
          REG_IER: r.read_data = dlab ? dlm_q : {4'h0, ier_q};
          REG_IIR: begin
            r.read_data = rx_cause() ? IIR_RDA : (tx_cause() ? IIR_THRE : IIR_NONE);
            if (fifo_en) r.read_data |= IIR_FIFOS;
          end
          REG_LCR: r.read_data = lcr_q;
          REG_LSR: begin
            if (rx_fill != 0) r.read_data |= LSR_DR;
            if (overrun) r.read_data |= LSR_OE;
            if (tx_fill == 0) r.read_data |= LSR_THRE | LSR_TEMT;
            overrun = 1'b0;
          end
          default: ;
        endcase
      end
      CMD_WRITE: begin
        case (w.reg_offset)
          REG_DATA: begin
            if (dlab) begin
              dll_q = w.write_data;
            end else if (tx_fill < room) begin
              tx_fifo[(tx_rd + tx_fill) % FIFO_DEPTH] = w.write_data;
              tx_fill++;
            end
          end
          REG_IER: begin
            if (dlab) dlm_q = w.write_data;
            else ier_q = w.write_data[3:0];
          end
          REG_FCR: begin
            // a change of mode flushes both sides, else with fifos on bits 1 and 2 flush
            if (w.write_data[0] != fifo_en) begin
              fifo_en = w.write_data[0];
              rx_fill = 0; rx_rd = 0;
              tx_fill = 0; tx_rd = 0;
            end else if (fifo_en) begin
              if (w.write_data[1]) begin rx_fill = 0; rx_rd = 0; end
              if (w.write_data[2]) begin tx_fill = 0; tx_rd = 0; end
            end
          end
          REG_LCR: lcr_q = w.write_data;
          default: ;
        endcase
      end
      CMD_RECEIVE: begin
        if (rx_fill < room) begin
          rx_fifo[(rx_rd + rx_fill) % FIFO_DEPTH] = w.line_byte;
          rx_fill++;
        end else begin
          overrun = 1'b1;
          overrun_count++;
          // single-byte mode keeps the newest byte
          if (!fifo_en) rx_fifo[rx_rd] = w.line_byte;
        end
      end
      CMD_TICK: begin
        if (tx_fill != 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte = tx_fifo[tx_rd];
          tx_rd = (tx_rd + 1) % FIFO_DEPTH;
          tx_fill--;
          line_bytes++;
        end
      end
      default: ;
    endcase
    r.irq = rx_cause() || tx_cause();
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t make_word(input command_t c, input logic [2:0] off,
                                     input logic [7:0] wd, input logic [7:0] lb);
    req_t w;
    w.command = c;
    w.reg_offset = off;
    w.write_data = wd;
    w.line_byte = lb;
    return w;
  endfunction

  task automatic send_word(input req_t w);
    int unsigned gap;
    gap = req_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    expected_rsp.push_back(predict_response(w));
    words_sent++;
  endtask

  task automatic bus_read(input logic [2:0] off);
    send_word(make_word(CMD_READ, off, 8'($urandom), 8'($urandom)));
  endtask

  task automatic bus_write(input logic [2:0] off, input logic [7:0] data);
    send_word(make_word(CMD_WRITE, off, data, 8'($urandom)));
  endtask

  task automatic line_rx(input logic [7:0] data);
    send_word(make_word(CMD_RECEIVE, 3'($urandom), 8'($urandom), data));
  endtask

  task automatic tx_tick();
    send_word(make_word(CMD_TICK, 3'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  // response side: short random stalls, or one long hold-off on request
  initial begin : rsp_sink
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
        rsp_ready <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= 10)
        $display("word %0d: %s expected %02h got %02h", rsp_seen, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("word %0d: response with nothing outstanding", rsp_seen);
      end else begin
        oldest = expected_rsp.pop_front();
        check_field("read_data", oldest.read_data, rsp.read_data);
        check_field("tx_valid", oldest.tx_valid, rsp.tx_valid);
        check_field("tx_byte", oldest.tx_byte, rsp.tx_byte);
        check_field("irq", oldest.irq, rsp.irq);
      end
      rsp_seen++;
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no handshake for %0d cycles, %0d words outstanding", idle_cycles,
               expected_rsp.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_register_access();
    bus_read(REG_LSR);
    bus_read(REG_IIR);
    bus_write(REG_IER, 8'hFF);
    bus_read(REG_IER);
    bus_write(REG_LCR, 8'h80);
    bus_write(REG_DATA, 8'hFF);
    bus_write(REG_IER, 8'hA5);
    bus_read(REG_DATA);
    bus_read(REG_IER);
    bus_write(REG_LCR, 8'h7F);
    bus_read(REG_LCR);
    bus_write(REG_MCR, 8'hFF);
    bus_write(REG_LSR, 8'hFF);
    bus_read(REG_MSR);
    bus_read(REG_SCR);
  endtask

  task automatic test_single_byte_mode();
    line_rx(8'h00);
    line_rx(8'hFF);   // overrun replaces the held byte
    bus_read(REG_LSR);
    bus_read(REG_DATA);
    bus_read(REG_DATA);
    bus_write(REG_DATA, 8'h00);
    bus_write(REG_DATA, 8'hFF);   // dropped, holding register full
    tx_tick();
    tx_tick();
  endtask

  task automatic test_fifo_control();
    bus_write(REG_FCR, 8'h01);
    line_rx(8'h5A);
    bus_write(REG_DATA, 8'hC3);
    bus_read(REG_IIR);
    bus_write(REG_FCR, 8'h03);
    bus_write(REG_FCR, 8'h05);
    bus_read(REG_LSR);
    bus_write(REG_FCR, 8'hFE);
    bus_write(REG_FCR, 8'hFF);
  endtask

  task automatic test_backpressure();
    req_gaps_on = 1'b0;
    hold_request = 1'b1;
    repeat (40) begin
      case ($urandom_range(0, 3))
        0: line_rx(8'($urandom));
        1: bus_write(REG_DATA, 8'($urandom));
        2: bus_read(REG_DATA);
        default: tx_tick();
      endcase
    end
    req_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned n;
    int unsigned roll;
    logic [7:0]  fcr;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) req_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) rsp_gaps_on = ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 99);
      // leave the divisor latch mostly so data bursts reach the fifos
      if (roll < 55 && lcr_q[DLAB_POS] && $urandom_range(0, 3) != 0)
        bus_write(REG_LCR, 8'($urandom) & 8'h7F);
      if (roll < 30) begin
        n = $urandom_range(1, FIFO_DEPTH + 4);
        repeat (n) line_rx(8'($urandom));
        if ($urandom_range(0, 1) == 0) bus_read(REG_LSR);
        repeat ($urandom_range(0, n + 2)) bus_read(REG_DATA);
      end else if (roll < 55) begin
        n = $urandom_range(1, FIFO_DEPTH + 4);
        repeat (n) begin
          bus_write(REG_DATA, 8'($urandom));
          if ($urandom_range(0, 3) == 0) tx_tick();
        end
        if ($urandom_range(0, 1) == 0) bus_read(REG_LSR);
        repeat ($urandom_range(0, n + 2)) tx_tick();
      end else if (roll < 65) begin
        bus_write(REG_IER, 8'($urandom));
        bus_read($urandom_range(0, 1) ? REG_IIR : REG_IER);
      end else if (roll < 73) begin
        fcr = 8'($urandom);
        if ($urandom_range(0, 4) != 0) fcr[0] = fifo_en;
        bus_write(REG_FCR, fcr);
        bus_read(REG_IIR);
      end else if (roll < 80) begin
        bus_write(REG_LCR, 8'($urandom) | 8'h80);
        bus_write(REG_DATA, 8'($urandom));
        bus_write(REG_IER, 8'($urandom));
        bus_read(REG_DATA);
        bus_read(REG_IER);
        bus_read(REG_LCR);
      end else begin
        repeat ($urandom_range(1, 6))
          send_word(make_word(command_t'($urandom_range(0, 3)), 3'($urandom),
                              8'($urandom), 8'($urandom)));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_single_byte_mode();
    test_fifo_control();
    test_backpressure();
    test_random_traffic(RANDOM_WORDS);
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d request words, %0d responses checked, %0d receive overruns, %0d bytes to line",
             words_sent, rsp_seen, overrun_count, line_bytes);
    $display("single-byte and fifo modes, divisor latch, fcr flushes and a long response stall");
    if (error_count == 0 && expected_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
